// ===== rtl/rdc_pkg.sv =====
// rdc_pkg: shared types, constants and helpers for the radix digit converter
// no dependencies; imported by every rdc module and by the top level

package rdc_pkg;

  localparam int unsigned VALUE_BITS_DEF = 63;
  localparam int unsigned MAX_DIGITS_DEF = 64;

  localparam int unsigned BASE_W  = 9;
  localparam int unsigned DIGIT_W = 8;

  localparam logic [BASE_W-1:0] BASE_RESET = 9'd10;
  localparam logic [BASE_W-1:0] BASE_MIN   = 9'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 9'd256;

  // quotient bits resolved per divider cycle
  localparam int unsigned RADIX_BITS = 4;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               msd;    // most significant digit of this value, produced last
  } digit_beat_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BS_FILL,
    BS_RD,
    BS_OUT
  } back_state_e;

  // clamp the programmed radix into 2..256
  function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end
    return r;
  endfunction

endpackage

// ===== rtl/rdc_front.sv =====
// rdc_front: accepts values and splits them into digits, least significant first
// shared restoring divider, RADIX_BITS quotient bits per cycle; uses rdc_pkg

module rdc_front import rdc_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [BASE_W-1:0]     base_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output digit_beat_t           q_beat_o
);

  localparam int unsigned STEPS  = (VALUE_BITS + RADIX_BITS - 1) / RADIX_BITS;
  localparam int unsigned PAD_W  = STEPS * RADIX_BITS;
  localparam int unsigned STEP_W = $clog2(STEPS);
  localparam int unsigned CNT_W  = $clog2(MAX_DIGITS);

  front_state_e       state_q, state_d;
  logic [PAD_W-1:0]   quo_q, quo_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [BASE_W-1:0]  base_q, base_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               msd_q, msd_d;

  logic [PAD_W-1:0]   div_quo;
  logic [DIGIT_W-1:0] div_rem;

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_comb begin
    logic [BASE_W-1:0] trial;
    div_rem = rem_q;
    div_quo = quo_q;
    trial   = '0;
    for (int j = 0; j < RADIX_BITS; j++) begin
      trial   = {div_rem, div_quo[PAD_W-1]};
      div_quo = {div_quo[PAD_W-2:0], 1'b0};
      if (trial >= base_q) begin
        trial      = trial - base_q;
        div_quo[0] = 1'b1;
      end
      div_rem = trial[DIGIT_W-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    base_d     = base_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    msd_d      = msd_q;
    in_ready_o = 1'b0;
    q_valid_o  = 1'b0;
    case (state_q)
      FS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          quo_d   = PAD_W'(value_i);
          rem_d   = '0;
          base_d  = base_i;
          step_d  = '0;
          cnt_d   = '0;
          state_d = FS_DIV;
        end
      end
      FS_DIV: begin
        quo_d  = div_quo;
        rem_d  = div_rem;
        step_d = STEP_W'(step_q + 1'b1);
        if (step_q == STEP_W'(STEPS - 1)) begin
          msd_d   = (div_quo == '0) || (cnt_q == CNT_W'(MAX_DIGITS - 1));
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        q_valid_o = 1'b1;
        if (q_ready_i) begin
          if (msd_q) begin
            state_d = FS_IDLE;
          end else begin
            cnt_d   = CNT_W'(cnt_q + 1'b1);
            rem_d   = '0;
            step_d  = '0;
            state_d = FS_DIV;
          end
        end
      end
      default: begin
        state_d = FS_IDLE;
      end
    endcase
  end

  assign q_beat_o.digit = rem_q;
  assign q_beat_o.msd   = msd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    base_q <= base_d;
    step_q <= step_d;
    cnt_q  <= cnt_d;
    msd_q  <= msd_d;
  end

endmodule

// ===== rtl/rdc_queue.sv =====
// rdc_queue: short digit queue between divider front and read-out back
// QUEUE_DEPTH entries of digit_beat_t; uses rdc_pkg

module rdc_queue import rdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  digit_beat_t push_beat_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output digit_beat_t pop_beat_o
);

  digit_beat_t         entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     fill_q, fill_d;
  logic                push, pop;

  assign push_ready_o = (fill_q != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_beat_o   = entry_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      fill_d = (QPTR_W + 1)'(fill_q + 1'b1);
    end else if (pop && !push) begin
      fill_d = (QPTR_W + 1)'(fill_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_beat_i;
    end
  end

endmodule

// ===== rtl/rdc_back.sv =====
// rdc_back: stacks the digits of one value and plays them out most significant first
// digit stack memory with registered read, output register; uses rdc_pkg

module rdc_back import rdc_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  digit_beat_t        q_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DIGIT_W-1:0] digit_o,
  output logic               last_digit_o
);

  localparam int unsigned AW = $clog2(MAX_DIGITS);

  back_state_e        state_q, state_d;
  logic [AW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]      rd_idx_q, rd_idx_d;
  logic               out_valid_q, out_valid_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic               last_q, last_d;

  logic [DIGIT_W-1:0] stack_mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_q;
  logic               wr_en;

  assign q_ready_o = (state_q == BS_FILL);
  assign wr_en     = (state_q == BS_FILL) && q_valid_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_ptr_q] <= q_beat_i.digit;
    end
    rd_data_q <= stack_mem[rd_idx_q];
  end

  always_comb begin
    state_d     = state_q;
    wr_ptr_d    = wr_ptr_q;
    rd_idx_d    = rd_idx_q;
    digit_d     = digit_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      BS_FILL: begin
        if (q_valid_i) begin
          if (q_beat_i.msd) begin
            rd_idx_d = wr_ptr_q;
            wr_ptr_d = '0;
            state_d  = BS_RD;
          end else begin
            wr_ptr_d = AW'(wr_ptr_q + 1'b1);
          end
        end
      end
      BS_RD: begin
        // read data lands in rd_data_q for the next cycle
        state_d = BS_OUT;
      end
      BS_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          digit_d     = rd_data_q;
          last_d      = (rd_idx_q == '0);
          if (rd_idx_q == '0) begin
            state_d = BS_FILL;
          end else begin
            rd_idx_d = AW'(rd_idx_q - 1'b1);
            state_d  = BS_RD;
          end
        end
      end
      default: begin
        state_d = BS_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_FILL;
      wr_ptr_q    <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    last_q  <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign digit_o      = digit_q;
  assign last_digit_o = last_q;

endmodule

// ===== rtl/radix_digit_converter_core.sv =====
// radix_digit_converter_core: top level of the radix digit converter
// instantiates rdc_front, rdc_queue and rdc_back; uses rdc_pkg

// Splits each accepted value into digits of the programmed base (2 to 256; lower
// settings act as 2, higher as 256) and returns one beat per digit, most significant
// first, with last_digit_o set on the least significant one; zero gives a single 0.
// The base is sampled when a value is accepted. Each digit is worked out in the
// shared divider (four quotient bits per cycle) and then pushed to the queue. The
// back end stacks the digits in a memory and, once the top digit is known, plays
// them out through a registered memory read and an output register, taking no new
// digits from the queue until it has passed on the last one; a four-beat queue lets
// the divider start on the next value while the previous one is still being read out.

module radix_digit_converter_core import rdc_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [BASE_W-1:0]     cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DIGIT_W-1:0]    digit_o,
  output logic                  last_digit_o
);

  logic [BASE_W-1:0] digit_base_q, digit_base_d;
  logic [BASE_W-1:0] base_eff;

  logic        fq_valid, fq_ready;
  digit_beat_t fq_beat;
  logic        qb_valid, qb_ready;
  digit_beat_t qb_beat;

  assign digit_base_d = cfg_we_i ? cfg_wdata_i : digit_base_q;
  assign base_eff     = eff_base(digit_base_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_base_q <= BASE_RESET;
    end else begin
      digit_base_q <= digit_base_d;
    end
  end

  rdc_front #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .base_i     (base_eff),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_beat_o   (fq_beat)
  );

  rdc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_beat_i  (fq_beat),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_beat_o   (qb_beat)
  );

  rdc_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (qb_valid),
    .q_ready_o    (qb_ready),
    .q_beat_i     (qb_beat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_o      (digit_o),
    .last_digit_o (last_digit_o)
  );

  // divider must be busy right after taking a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("front still ready after accepting a value");

  // once the top digit has left the divider it is free for the next value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_valid && fq_ready && fq_beat.msd |=> in_ready_o)
    else $error("front not idle after its final digit beat");

  // every remainder is below the currently programmed base, after clamping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_valid |-> ({1'b0, fq_beat.digit} < base_eff))
    else $error("digit not below base");

  // a digit from the queue must never be dropped while the back end plays out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qb_valid && !qb_ready |=> qb_valid)
    else $error("queued digit lost");

endmodule

// ===== dv/radix_digit_converter_core_test.sv =====
`timescale 1ns / 100ps
// radix_digit_converter_core_test: self-checking bench for the radix digit converter
// predicts the digit beats of every accepted value and checks them in order
// depends on rdc_pkg and radix_digit_converter_core

module radix_digit_converter_core_test;
  import rdc_pkg::*;

  localparam int unsigned VW             = VALUE_BITS_DEF;
  localparam int unsigned NDIG           = MAX_DIGITS_DEF;
  localparam int unsigned RX_HOLD_CYCLES = 2500;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               is_last;
  } digit_due_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [BASE_W-1:0]  cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [VW-1:0]      value_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [DIGIT_W-1:0] digit_o;
  logic               last_digit_o;

  logic [BASE_W-1:0] digit_base_shadow = BASE_RESET;
  logic [VW-1:0]     values_pending[$];
  digit_due_t        digits_due[$];
  digit_due_t        due;
  int unsigned       values_queued   = 0;
  int unsigned       values_taken    = 0;
  int unsigned       beats_checked   = 0;
  int unsigned       mismatch_count  = 0;
  int unsigned       tx_idle_pct     = 25;
  int unsigned       rx_idle_pct     = 25;
  int unsigned       rx_hold_left    = 0;
  bit                rx_hold_req     = 1'b0;
  bit                rx_hold_ack     = 1'b0;

  radix_digit_converter_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_o      (digit_o),
    .last_digit_o (last_digit_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] beat %0d: %s", $time, beats_checked, msg);
    mismatch_count++;
  endtask

  // splits a value into digits of the shadowed base, most significant first
  function automatic void predict_digits(input logic [VW-1:0] value);
    logic [VW-1:0]      rest;
    logic [VW-1:0]      radix;
    logic [DIGIT_W-1:0] lsd_first[$];
    digit_due_t         d;
    rest  = value;
    radix = VW'(digit_base_shadow);
    if (digit_base_shadow < BASE_MIN) begin
      radix = VW'(BASE_MIN);
    end else if (digit_base_shadow > BASE_MAX) begin
      radix = VW'(BASE_MAX);
    end
    do begin
      lsd_first = {lsd_first, DIGIT_W'(rest % radix)};
      rest = rest / radix;
    end while (rest != '0 && lsd_first.size() < NDIG);
    while (lsd_first.size() > 0) begin
      d.digit   = lsd_first.pop_back();
      d.is_last = (lsd_first.size() == 0);
      digits_due = {digits_due, d};
    end
  endfunction

  // sender: one value per beat from the pending queue
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_digits(value_i);
        values_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (values_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          value_i    <= values_pending.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each digit beat against the oldest prediction and drives out_ready_i
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (digits_due.size() == 0) begin
          report_mismatch($sformatf("digit %0d arrived with nothing outstanding", digit_o));
        end else begin
          due = digits_due.pop_front();
          if (digit_o !== due.digit) begin
            report_mismatch($sformatf("digit got %0d, expected %0d", digit_o, due.digit));
          end
          if (last_digit_o !== due.is_last) begin
            report_mismatch($sformatf("last_digit got %0b, expected %0b",
                                      last_digit_o, due.is_last));
          end
        end
        beats_checked++;
      end
      if (rx_hold_req != rx_hold_ack) begin
        rx_hold_ack  <= rx_hold_req;
        rx_hold_left <= RX_HOLD_CYCLES;
        out_ready_i  <= 1'b0;
      end else if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_ready_i  <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [VW-1:0] rand_value();
    logic [VW-1:0] raw;
    raw = VW'({$urandom, $urandom});
    case ($urandom_range(7))
      0: return raw;
      1: return VW'($urandom_range(300));
      default: return raw >> $urandom_range(VW - 1);
    endcase
  endfunction

  task automatic queue_value(input logic [VW-1:0] v);
    values_pending = {values_pending, v};
    values_queued++;
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) queue_value(rand_value());
  endtask

  task automatic wait_drained();
    while (values_taken != values_queued || digits_due.size() != 0) @(posedge clk_i);
  endtask

  // the base may only change with nothing in flight
  task automatic set_digit_base(input logic [BASE_W-1:0] raw);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i          <= 1'b1;
    cfg_wdata_i       <= raw;
    digit_base_shadow  = raw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset base of ten
    queue_value('0);
    queue_value(VW'(1));
    queue_value(VW'(9));
    queue_value(VW'(10));
    queue_value(VW'(64'd999_999_999_999_999_999));
    queue_value({VW{1'b1}});
    queue_value(VW'(1) << (VW - 1));
    queue_value(VW'(64'h2AAA_AAAA_AAAA_AAAA));
    queue_value(VW'(64'h5555_5555_5555_5555));

    // zero saturates to base two: widest digit strings
    set_digit_base('0);
    queue_value({VW{1'b1}});
    queue_value('0);
    queue_value(VW'(1));
    queue_value(VW'(2));
    queue_random(24);

    // all ones saturates to base 256
    set_digit_base({BASE_W{1'b1}});
    queue_value(VW'(255));
    queue_value(VW'(256));
    queue_value({VW{1'b1}});
    queue_value('0);
    queue_random(50);

    // a stretch with no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_digit_base(BASE_MIN);
    queue_random(40);
    wait_drained();
    rx_idle_pct = 25;

    // long receiver hold while short values keep coming, so the block backs up
    set_digit_base(BASE_MAX);
    rx_hold_req <= ~rx_hold_req;
    repeat (40) queue_value(VW'($urandom_range(65535)));
    wait_drained();
    tx_idle_pct = 25;

    set_digit_base(BASE_W'(BASE_MAX + 1));
    queue_random(30);
    set_digit_base(BASE_W'(1));
    queue_random(16);
    set_digit_base(BASE_W'(BASE_MAX - 1));
    queue_random(40);
    repeat (6) begin
      set_digit_base(BASE_W'($urandom_range(511)));
      queue_random(40);
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
